[rtl/core/park_miller_random_draw_core_defines.svh]
// assertion macros shared by the random draw core
// expects signals named clock and reset in the module that uses them
`ifndef PARK_MILLER_RANDOM_DRAW_CORE_DEFINES_SVH
`define PARK_MILLER_RANDOM_DRAW_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define PMRD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pmrd assertion failed");

// condition in one cycle implies a condition in the next
`define PMRD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmrd assertion failed");

`endif

[rtl/core/pmrd_pkg.sv]
// shared types, constants and helper functions of the random draw core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pmrd_pkg;

   localparam int OpW       = 3;
   localparam int CountW    = 7;
   localparam int DataW     = 32;
   localparam int StateW    = 31;
   localparam int MulW      = 15;
   localparam int ProdW     = StateW + MulW;
   localparam int FracW     = 27;
   localparam int DiffW     = DataW + 1;
   localparam int ScaleW    = DiffW + FracW + 1;

   localparam int MaxBytesDefault = 64;

   localparam logic [MulW-1:0]  LcgMul   = 15'd16807;
   localparam logic [DataW-1:0] LcgMod   = 32'h7fff_ffff;
   localparam logic [DataW-1:0] SeedInit = 32'd1;
   localparam logic [StateW-1:0] StateInit = 31'd1;

   typedef enum logic [OpW-1:0] {
      OP_RESEED = 3'd0,
      OP_INT    = 3'd1,
      OP_BOOL   = 3'd2,
      OP_FRAC   = 3'd3,
      OP_BYTES  = 3'd4
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL_A = 7'b0000010,
      ST_RED_A = 7'b0000100,
      ST_MUL_B = 7'b0001000,
      ST_RED_B = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic   load_req;
      logic   load_seed;
      logic   red_a;
      logic   red_b;
      logic   scale;
      logic   emit;
      logic   last;
      op_type kind;
   } cmd_type;

   // one conditional subtract brings a folded value below the modulus
   function automatic logic [StateW-1:0] mod_fold(input logic [DataW-1:0] x);
      logic [DataW-1:0] y;
      y = (x >= LcgMod) ? (x - LcgMod) : x;
      return y[StateW-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/pmrd_if.sv]
// request and response channel interfaces of the random draw core
// depends on pmrd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pmrd_req_if import pmrd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OpW-1:0]           op;
   logic signed [DataW-1:0]  min_value;
   logic signed [DataW-1:0]  max_value;
   logic [CountW-1:0]        byte_count;

   modport source (output valid, op, min_value, max_value, byte_count, input ready);
   modport sink   (input valid, op, min_value, max_value, byte_count, output ready);
endinterface

interface pmrd_rsp_if import pmrd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DataW-1:0]  result_value;
   logic                     last;

   modport source (output valid, result_value, last, input ready);
   modport sink   (input valid, result_value, last, output ready);
endinterface

`default_nettype wire

[rtl/core/park_miller_random_draw_core.sv]
// random draw core: minimal standard generator with range, bool, fraction
// and byte draws. Requests come in on req (op, min_value, max_value,
// byte_count); results leave on rsp (result_value, last) with valid/ready.
// csr_write_enable/csr_write_data load the seed used by a reseed request.
// One request is worked at a time; req ready is high only while idle.
// Each draw makes two passes through the 31x15 constant multiplier and
// the mod 2^31-1 fold, each a multiply state and a reduce state.
// Bool and fraction results are loaded into the output register after
// the second reduce; integer results first pass through the scale state
// for the 33x28 range multiply. A byte request gives one byte per draw;
// last marks the final byte. A reseed returns nothing, and the next
// request can be accepted once its draw steps are done. With no stall a
// new request is taken the cycle after the last result is loaded.
// A stalled receiver holds the output register; the next draw is then held
// too, so no result is dropped. Reset clears the generator state to 1, the
// seed to 1 and drops any pending result. Depends on pmrd_pkg, pmrd_if,
// pmrd_ctrl and pmrd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module park_miller_random_draw_core import pmrd_pkg::*; #(
   parameter int MAX_BYTES = MaxBytesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [DataW-1:0] csr_write_data,
   pmrd_req_if.sink              req,
   pmrd_rsp_if.source            rsp
);

   cmd_type cmd;

   pmrd_ctrl #(
      .MAX_BYTES (MAX_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_op         (req.op),
      .req_byte_count (req.byte_count),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .cmd            (cmd)
   );

   pmrd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_min_value    (req.min_value),
      .req_max_value    (req.max_value),
      .cmd              (cmd),
      .rsp_result_value (rsp.result_value),
      .rsp_last         (rsp.last)
   );

endmodule

`default_nettype wire

[rtl/core/pmrd_ctrl.sv]
// sequencer of the random draw core: op decode, draw steps, byte count
// depends on pmrd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "park_miller_random_draw_core_defines.svh"

module pmrd_ctrl import pmrd_pkg::*; #(
   parameter int MAX_BYTES = MaxBytesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [OpW-1:0]    req_op,
   input  wire logic [CountW-1:0] req_byte_count,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      cmd_type           cmd
);

   localparam int CntW = $clog2(MAX_BYTES + 1);
   localparam logic [CountW-1:0] MaxCnt = CountW'(MAX_BYTES);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_fire;
   logic              out_free;
   logic [CountW-1:0] clipped;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign clipped   = (req_byte_count > MaxCnt) ? MaxCnt : req_byte_count;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.kind      = op_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load_req = 1'b1;
               op_in        = op_type'(req_op);
               unique case (req_op)
                  OP_RESEED: begin
                     cmd.load_seed = 1'b1;
                     state_in      = ST_MUL_A;
                  end
                  OP_INT, OP_BOOL, OP_FRAC: begin
                     state_in = ST_MUL_A;
                  end
                  OP_BYTES: begin
                     cnt_in = CntW'(clipped);
                     if (clipped != '0) begin
                        state_in = ST_MUL_A;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL_A: begin
            state_in = ST_RED_A;
         end
         ST_RED_A: begin
            cmd.red_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            state_in = ST_RED_B;
         end
         ST_RED_B: begin
            cmd.red_b = 1'b1;
            unique case (op_ff)
               OP_RESEED: state_in = ST_IDLE;
               OP_INT:    state_in = ST_SCALE;
               default:   state_in = ST_EMIT;
            endcase
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               cmd.last     = (op_ff != OP_BYTES) || (cnt_ff == CntW'(1));
               rsp_valid_in = 1'b1;
               // the product of the new state is already registered
               if ((op_ff == OP_BYTES) && (cnt_ff > CntW'(1))) begin
                  cnt_in   = cnt_ff - CntW'(1);
                  state_in = ST_RED_A;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RESEED;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PMRD_ASSERT_NEXT(a_draw_start, req_fire && (req_op == OP_RESEED || req_op == OP_INT || req_op == OP_BOOL || req_op == OP_FRAC), state_ff == ST_MUL_A)
   `PMRD_ASSERT(a_cnt_live, (state_ff != ST_IDLE && op_ff == OP_BYTES) |-> (cnt_ff != '0))
   `PMRD_ASSERT_NEXT(a_reseed_end, state_ff == ST_RED_B && op_ff == OP_RESEED, state_ff == ST_IDLE)

endmodule

`default_nettype wire

[rtl/core/pmrd_datapath.sv]
// datapath of the random draw core: generator state, modular multiply,
// draw sum, range scaling and output register; depends on pmrd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmrd_datapath import pmrd_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [DataW-1:0]        csr_write_data,
   input  wire logic signed [DataW-1:0] req_min_value,
   input  wire logic signed [DataW-1:0] req_max_value,
   input  wire cmd_type                 cmd,
   output      logic signed [DataW-1:0] rsp_result_value,
   output      logic                    rsp_last
);

   logic [DataW-1:0]         seed_ff, seed_in;
   logic [StateW-1:0]        state_ff, state_in;
   logic [ProdW-1:0]         prod_ff, prod_in;
   logic [StateW-1:0]        s1_ff, s1_in;
   logic [DataW-1:0]         sum_ff, sum_in;
   logic signed [DataW-1:0]  min_ff, min_in;
   logic signed [DiffW-1:0]  diff_ff, diff_in;
   logic signed [ScaleW-1:0] scale_ff, scale_in;
   logic signed [DataW-1:0]  value_ff, value_in;
   logic                     last_ff, last_in;

   logic [StateW-1:0]        lcg_red;
   logic [StateW-1:0]        seed_red;
   logic [FracW-1:0]         frac;
   logic [FracW+7:0]         byte_prod;
   logic [DataW-1:0]         int_res;

   always_comb begin
      // 2^31 = 1 mod (2^31-1): fold the high bits onto the low ones
      lcg_red  = mod_fold({1'b0, prod_ff[StateW-1:0]} + DataW'(prod_ff[ProdW-1:StateW]));
      seed_red = mod_fold({1'b0, seed_ff[StateW-1:0]} + DataW'(seed_ff[DataW-1]));
      frac     = sum_ff[FracW-1:0];
      byte_prod = {frac, 8'h00} - (FracW+8)'(frac);
      // floor shift keeps only the low result bits that matter
      int_res  = min_ff + scale_ff[FracW+DataW-1:FracW];

      seed_in  = csr_write_enable ? csr_write_data : seed_ff;
      prod_in  = ProdW'(state_ff) * ProdW'(LcgMul);
      state_in = state_ff;
      s1_in    = s1_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      diff_in  = diff_ff;
      scale_in = scale_ff;
      value_in = value_ff;
      last_in  = last_ff;

      if (cmd.load_req) begin
         min_in  = req_min_value;
         diff_in = DiffW'(req_max_value) - DiffW'(req_min_value);
      end
      if (cmd.load_seed) begin
         state_in = seed_red;
      end
      if (cmd.red_a) begin
         state_in = lcg_red;
         s1_in    = lcg_red;
      end
      if (cmd.red_b) begin
         state_in = lcg_red;
         sum_in   = DataW'(s1_ff) + DataW'(lcg_red[15:8]);
      end
      if (cmd.scale) begin
         scale_in = diff_ff * $signed({1'b0, frac});
      end
      if (cmd.emit) begin
         last_in = cmd.last;
         case (cmd.kind)
            OP_INT:   value_in = int_res;
            OP_BOOL:  value_in = DataW'(sum_ff[8]);
            OP_FRAC:  value_in = DataW'(frac);
            OP_BYTES: value_in = DataW'(byte_prod[FracW+7:FracW]);
            default:  value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SeedInit;
         state_ff <= StateInit;
      end else begin
         seed_ff  <= seed_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      s1_ff    <= s1_in;
      sum_ff   <= sum_in;
      min_ff   <= min_in;
      diff_ff  <= diff_in;
      scale_ff <= scale_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_result_value = value_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire
